FILE: sv/rmlp_pkg.sv
package rmlp_pkg;

    localparam int NUM_INPUTS_DEF   = 8;
    localparam int HIDDEN_ROWS_DEF  = 8;
    localparam int HIDDEN_COLS_DEF  = 2;
    localparam int NUM_OUTPUTS_DEF  = 4;
    localparam int WEIGHT_DEPTH_DEF = 256;

    localparam int VAL_W  = 16;
    localparam int IDX_W  = 8;
    localparam int ACT_W  = 13;
    localparam int OPND_W = 17;
    localparam int PROD_W = 33;
    localparam int ACC_W  = 40;
    localparam int DIV_W  = 54;
    localparam int DEN_W  = 42;
    localparam int QUO_W  = 12;
    localparam int DIV_STEPS = 12;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [1:0] MODE_WEIGHT = 2'd0;
    localparam logic [1:0] MODE_INPUT  = 2'd1;
    localparam logic [1:0] MODE_RUN    = 2'd2;

    typedef struct packed {
        logic [1:0]              mode;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]       out_index;
        logic [ACT_W-1:0] out_value;
        logic             last;
    } t_out_item;

    typedef enum logic [1:0] {
        K_WEIGHT,
        K_INPUT,
        K_RUN
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

FILE: sv/rmlp_ram.sv
module rmlp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/rmlp_div.sv
module rmlp_div
    import rmlp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ACC_W-1:0] i_mag,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo
);

    logic [DEN_W-1:0] den;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_dsh;
    logic [QUO_W-1:0] r_quo;
    logic [3:0]       r_cnt;
    logic             r_run;
    logic             r_done;
    logic             fits;

    // round(mag*2^13 / (2^24 + 4*mag)): remainder starts at num + den/2
    assign den  = DEN_W'({i_mag, 2'b00}) + DEN_W'(24'hFFFFFF) + DEN_W'(1);
    assign fits = (r_rem >= r_dsh);
    assign n_rem = fits ? (r_rem - r_dsh) : r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DIV_W'({i_mag, 13'b0}) + DIV_W'(den >> 1);
            r_dsh <= DIV_W'({den, 11'b0});
            r_quo <= '0;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_dsh <= r_dsh >> 1;
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                if (r_cnt == 4'(DIV_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 4'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: sv/rmlp_front.sv
module rmlp_front
    import rmlp_pkg::*;
#(
    parameter int NUM_INPUTS   = NUM_INPUTS_DEF,
    parameter int WEIGHT_DEPTH = WEIGHT_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_item i_item,
    input  logic     i_pop,
    output logic     o_busy,
    output t_q_head  o_head
);

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              keep;
    t_cmd              cmd;
    logic              push;
    logic              pop;

    // sort out the item and drop anything with no effect
    always_comb begin
        keep      = 1'b0;
        cmd.kind  = K_RUN;
        cmd.index = i_item.index;
        cmd.value = i_item.value;
        unique case (i_item.mode)
            MODE_WEIGHT: begin
                cmd.kind = K_WEIGHT;
                keep     = (32'(i_item.index) < WEIGHT_DEPTH);
            end
            MODE_INPUT: begin
                cmd.kind = K_INPUT;
                keep     = (32'(i_item.index) < NUM_INPUTS);
            end
            MODE_RUN: begin
                cmd.kind = K_RUN;
                keep     = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_busy = (r_cnt == QCNT_W'(QDEPTH));
    assign push   = i_start && !o_busy && keep;
    assign pop    = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rp];

endmodule

FILE: sv/rmlp_back.sv
module rmlp_back
    import rmlp_pkg::*;
#(
    parameter int NUM_INPUTS   = NUM_INPUTS_DEF,
    parameter int HIDDEN_ROWS  = HIDDEN_ROWS_DEF,
    parameter int HIDDEN_COLS  = HIDDEN_COLS_DEF,
    parameter int NUM_OUTPUTS  = NUM_OUTPUTS_DEF,
    parameter int WEIGHT_DEPTH = WEIGHT_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_head   i_head,
    output logic      o_pop,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int NI = NUM_INPUTS;
    localparam int NR = HIDDEN_ROWS;
    localparam int NC = HIDDEN_COLS;
    localparam int NO = NUM_OUTPUTS;
    localparam int NH = NR * NC;
    localparam int TOTAL_W = NR * (NI + NO + 2) + (NC - 1) * NR * (NR + 2) + NO * NR;
    localparam int WCW = $clog2(TOTAL_W + 1);
    localparam int AW  = $clog2(WEIGHT_DEPTH);
    localparam int IW  = (NI > 1) ? $clog2(NI) : 1;
    localparam int OW  = (NO > 1) ? $clog2(NO) : 1;
    localparam int HW  = (NH > 1) ? $clog2(NH) : 1;
    localparam int TMAX = (NI + NO + 2 > NR + 2) ? (NI + NO + 2) : (NR + 2);
    localparam int TW  = $clog2(TMAX);
    localparam int RMAX = (NR > NO) ? NR : NO;
    localparam int RW  = (RMAX > 1) ? $clog2(RMAX) : 1;
    localparam int CW  = $clog2(NC + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TERM,
        S_DRAIN,
        S_DIV
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [TW-1:0]   r_term;
    logic [WCW-1:0]  r_waddr;
    logic            r_strobe;
    t_out_item       r_result;
    logic            r_neg;

    logic signed [VAL_W-1:0] r_in  [NI];
    logic [ACT_W-1:0]        r_hid [NH];
    logic [ACT_W-1:0]        r_out [NO];

    logic signed [OPND_W-1:0] r_opnd;
    logic                     r_p1_vld;
    logic                     r_p1_oor;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_p2_vld;
    logic signed [ACC_W-1:0]  r_acc;

    logic                     out_layer;
    logic [TW-1:0]            last_term;
    logic                     issue;
    logic                     pipe_empty;
    logic                     fin;
    logic                     div_start;
    logic                     div_done;
    logic [QUO_W-1:0]         quo;
    logic [ACC_W-1:0]         mag;
    logic signed [OPND_W-1:0] opnd;
    logic [VAL_W-1:0]         w_raw;
    logic signed [VAL_W-1:0]  w_val;
    logic                     w_oor;
    logic signed [ACC_W:0]    sum;
    logic [24:0]              a_cl;
    logic [25:0]              a_rnd;
    logic [ACT_W-1:0]         out_val;
    logic [ACT_W-1:0]         hid_val;
    logic                     ram_we;

    assign out_layer  = (r_col == CW'(NC));
    assign issue      = (r_state == S_TERM);
    assign pipe_empty = !r_p1_vld && !r_p2_vld;
    assign fin        = (r_state == S_DRAIN) && pipe_empty;
    assign div_start  = fin && !out_layer;
    assign o_pop      = (r_state == S_IDLE) && i_head.valid;
    assign ram_we     = o_pop && (i_head.cmd.kind == K_WEIGHT);
    assign w_oor      = !(32'(r_waddr) < WEIGHT_DEPTH);

    always_comb begin
        if (r_col == '0) begin
            last_term = TW'(NI + NO + 1);
        end else if (!out_layer) begin
            last_term = TW'(NR + 1);
        end else begin
            last_term = TW'(NR - 1);
        end
    end

    // operand for the current term
    always_comb begin
        if (r_col == '0) begin
            if (32'(r_term) < NI) begin
                opnd = OPND_W'(r_in[r_term[IW-1:0]]);
            end else if (32'(r_term) < NI + NO) begin
                opnd = OPND_W'({4'b0, r_out[OW'(32'(r_term) - NI)]});
            end else if (32'(r_term) == NI + NO) begin
                opnd = OPND_W'({4'b0, r_hid[HW'(r_row)]});
            end else begin
                opnd = OPND_W'(4096);
            end
        end else if (!out_layer) begin
            if (32'(r_term) < NR) begin
                opnd = OPND_W'({4'b0, r_hid[HW'((32'(r_col) - 1) * NR + 32'(r_term))]});
            end else if (32'(r_term) == NR) begin
                opnd = OPND_W'({4'b0, r_hid[HW'(32'(r_col) * NR + 32'(r_row))]});
            end else begin
                opnd = OPND_W'(4096);
            end
        end else begin
            opnd = OPND_W'({4'b0, r_hid[HW'((NC - 1) * NR + 32'(r_term))]});
        end
    end

    rmlp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (WEIGHT_DEPTH)
    ) u_wram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_head.cmd.index)),
        .i_wdata (i_head.cmd.value),
        .i_raddr (AW'(r_waddr)),
        .o_rdata (w_raw)
    );

    assign w_val = r_p1_oor ? '0 : signed'(w_raw);

    // MAC: issue -> multiply -> saturating accumulate
    assign sum = {r_acc[ACC_W-1], r_acc} + (ACC_W + 1)'(r_prod);

    always_ff @(posedge i_clk) begin
        r_opnd   <= opnd;
        r_p1_oor <= w_oor;
        r_prod   <= w_val * r_opnd;
        if (r_p2_vld) begin
            if (sum[ACC_W] != sum[ACC_W-1]) begin
                r_acc <= sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            end else begin
                r_acc <= sum[ACC_W-1:0];
            end
        end else if (r_state != S_TERM && !r_p1_vld) begin
            r_acc <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= issue;
            r_p2_vld <= r_p1_vld;
        end
    end

    assign mag = r_acc[ACC_W-1] ? (~r_acc + ACC_W'(1)) : r_acc;

    rmlp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (mag),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    assign hid_val = r_neg ? (ACT_W'(2048) - ACT_W'(quo)) : (ACT_W'(2048) + ACT_W'(quo));

    // output neuron: clamp to [0, 1.0] then round to Q.12
    always_comb begin
        if (r_acc[ACC_W-1]) begin
            a_cl = '0;
        end else if (r_acc > ACC_W'(25'h1000000)) begin
            a_cl = 25'h1000000;
        end else begin
            a_cl = r_acc[24:0];
        end
        a_rnd   = {1'b0, a_cl} + 26'd2048;
        out_val = a_rnd[24:12];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in  <= '{default: '0};
            r_hid <= '{default: '0};
            r_out <= '{default: '0};
        end else begin
            if (o_pop && i_head.cmd.kind == K_INPUT) begin
                r_in[IW'(i_head.cmd.index)] <= i_head.cmd.value;
            end
            if (r_state == S_DIV && div_done) begin
                r_hid[HW'(32'(r_col) * NR + 32'(r_row))] <= hid_val;
            end
            if (fin && out_layer) begin
                r_out[OW'(r_row)] <= out_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_neg <= r_acc[ACC_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_term   <= '0;
            r_waddr  <= '0;
            r_strobe <= 1'b0;
            r_result <= '0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_head.valid && i_head.cmd.kind == K_RUN) begin
                        r_state <= S_TERM;
                        r_col   <= '0;
                        r_row   <= '0;
                        r_term  <= '0;
                        r_waddr <= '0;
                    end
                end
                S_TERM: begin
                    r_waddr <= r_waddr + WCW'(1);
                    if (r_term == last_term) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_term <= r_term + TW'(1);
                    end
                end
                S_DRAIN: begin
                    if (pipe_empty) begin
                        if (out_layer) begin
                            r_strobe           <= 1'b1;
                            r_result.out_index <= 4'(r_row);
                            r_result.out_value <= out_val;
                            r_result.last      <= (r_row == RW'(NO - 1));
                            r_term             <= '0;
                            if (r_row == RW'(NO - 1)) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_row   <= r_row + RW'(1);
                                r_state <= S_TERM;
                            end
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_term  <= '0;
                        r_state <= S_TERM;
                        if (r_row == RW'(NR - 1)) begin
                            r_row <= '0;
                            r_col <= r_col + CW'(1);
                        end else begin
                            r_row <= r_row + RW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

FILE: sv/recurrent_mlp_forward_step_unit.sv
// Channel   Handshake            Payload
// input     start / busy         i_item   (mode, index, value)
// result    o_strobe, one cycle  o_result (out_index, out_value, last)
//
// The queue takes load items while a run is going and holds them until it ends.
// A run handles each hidden neuron as its terms, the MAC drain and a wait on the
// 12-step divider, and each output neuron as its HIDDEN_ROWS terms and the drain.
// The one weight RAM port sets the MAC rate.
// Reset is synchronous; it clears the queue, the input, hidden and output stores.
// Results cannot be held off; busy rises only when the two-deep queue is full.
module recurrent_mlp_forward_step_unit
    import rmlp_pkg::*;
#(
    parameter int NUM_INPUTS   = NUM_INPUTS_DEF,
    parameter int HIDDEN_ROWS  = HIDDEN_ROWS_DEF,
    parameter int HIDDEN_COLS  = HIDDEN_COLS_DEF,
    parameter int NUM_OUTPUTS  = NUM_OUTPUTS_DEF,
    parameter int WEIGHT_DEPTH = WEIGHT_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    t_q_head head;
    logic    pop;

    rmlp_front #(
        .NUM_INPUTS   (NUM_INPUTS),
        .WEIGHT_DEPTH (WEIGHT_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .i_pop   (pop),
        .o_busy  (busy),
        .o_head  (head)
    );

    rmlp_back #(
        .NUM_INPUTS   (NUM_INPUTS),
        .HIDDEN_ROWS  (HIDDEN_ROWS),
        .HIDDEN_COLS  (HIDDEN_COLS),
        .NUM_OUTPUTS  (NUM_OUTPUTS),
        .WEIGHT_DEPTH (WEIGHT_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

FILE: sv/rmlp_checker.sv
module rmlp_checker
    import rmlp_pkg::*;
#(
    parameter int NUM_OUTPUTS = NUM_OUTPUTS_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_strobe,
    input t_out_item o_result
);

    // each output needs its own MAC pass, so results never come back to back
    a_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results in consecutive cycles");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.out_value <= 13'd4096))
        else $error("output activation above 1.0");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> (o_result.out_index == 4'(NUM_OUTPUTS - 1)))
        else $error("last flag on wrong output");

    a_rst: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_strobe)
        else $error("result straight after reset");

endmodule

bind recurrent_mlp_forward_step_unit rmlp_checker #(
    .NUM_OUTPUTS (NUM_OUTPUTS)
) u_rmlp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
